FILE: rtl/core/uva_pkg.sv
// ----------------------------------------------------------------------------
// uva_pkg
// Shared types and codes for the uncertain value ALU pipeline.
// ----------------------------------------------------------------------------
package uva_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 16;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_SUB = 2'd1;
	localparam logic [1:0] CMD_MUL = 2'd2;
	localparam logic [1:0] CMD_DIV = 2'd3;

	localparam logic [1:0] STAT_OK  = 2'd0;
	localparam logic [1:0] STAT_DZ  = 2'd1;
	localparam logic [1:0] STAT_OVF = 2'd2;

	// error rule
	localparam logic [1:0] ERR_ZERO  = 2'd0;
	localparam logic [1:0] ERR_ONE   = 2'd1;
	localparam logic [1:0] ERR_WORST = 2'd2;

	localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic                       valid;
		logic [1:0]                 cmd;
		logic [1:0]                 kind;
		logic                       ov_end;
		logic                       dz_val;
		logic                       dz_err;
		logic                       a_neg;
		logic signed [DATA_W:0]     sum_v;
		logic signed [DATA_W:0]     sum_e;
	} ctrl_t;

endpackage

FILE: rtl/core/uva_front.sv
// ----------------------------------------------------------------------------
// uva_front
// Decode stage: interval ends, error rule and operand pairs for the units.
// ----------------------------------------------------------------------------
module uva_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [1:0]                          command,
	input  logic signed [uva_pkg::DATA_W-1:0]   a_value,
	input  logic signed [uva_pkg::DATA_W-1:0]   a_error,
	input  logic signed [uva_pkg::DATA_W-1:0]   b_value,
	input  logic signed [uva_pkg::DATA_W-1:0]   b_error,
	output uva_pkg::ctrl_t                      ctrl_s1,
	output logic signed [uva_pkg::DATA_W-1:0]   mx_s1 [0:2],
	output logic signed [uva_pkg::DATA_W-1:0]   my_s1 [0:2],
	output logic signed [uva_pkg::DATA_W-1:0]   dx_s1 [0:2],
	output logic signed [uva_pkg::DATA_W-1:0]   dy_s1 [0:2]
);

	localparam int W = uva_pkg::DATA_W;

	logic signed [W+1:0] ap, am, bp, bm;
	logic signed [W-1:0] sap, sam, sbp, sbm;
	logic                oap, oam, obp, obm;
	logic                ae_z, be_z;
	uva_pkg::ctrl_t      ctrl_d;
	logic signed [W-1:0] mx [0:2];
	logic signed [W-1:0] my [0:2];
	logic signed [W-1:0] dx [0:2];
	logic signed [W-1:0] dy [0:2];

	function automatic logic signed [W-1:0] clamp(input logic signed [W+1:0] v);
		logic signed [W-1:0] r;
		r = v[W-1:0];
		if (v > (W+2)'(uva_pkg::S_MAX))
			r = uva_pkg::S_MAX;
		else if (v < (W+2)'(uva_pkg::S_MIN))
			r = uva_pkg::S_MIN;
		return r;
	endfunction

	function automatic logic clipped(input logic signed [W+1:0] v);
		return (v > (W+2)'(uva_pkg::S_MAX)) || (v < (W+2)'(uva_pkg::S_MIN));
	endfunction

	always_comb begin
		ap  = (W+2)'(a_value) + (W+2)'(a_error);
		am  = (W+2)'(a_value) - (W+2)'(a_error);
		bp  = (W+2)'(b_value) + (W+2)'(b_error);
		bm  = (W+2)'(b_value) - (W+2)'(b_error);
		sap = clamp(ap);
		sam = clamp(am);
		sbp = clamp(bp);
		sbm = clamp(bm);
		oap = clipped(ap);
		oam = clipped(am);
		obp = clipped(bp);
		obm = clipped(bm);
		ae_z = (a_error == '0);
		be_z = (b_error == '0);

		ctrl_d        = '0;
		ctrl_d.valid  = in_valid;
		ctrl_d.cmd    = command;
		ctrl_d.a_neg  = a_value[W-1];
		ctrl_d.sum_v  = (command == uva_pkg::CMD_SUB) ?
			(W+1)'(a_value) - (W+1)'(b_value) : (W+1)'(a_value) + (W+1)'(b_value);
		ctrl_d.sum_e  = (W+1)'(a_error) + (W+1)'(b_error);

		mx[0] = a_value;  my[0] = b_value;
		mx[1] = a_error;  my[1] = b_value;
		mx[2] = sam;      my[2] = sbm;
		dx[0] = a_value;  dy[0] = b_value;
		dx[1] = a_error;  dy[1] = b_value;
		dx[2] = sam;      dy[2] = sbp;

		if (ae_z && be_z)
			ctrl_d.kind = uva_pkg::ERR_ZERO;
		else if (command == uva_pkg::CMD_MUL) begin
			if (ae_z) begin
				ctrl_d.kind = uva_pkg::ERR_ONE;
				mx[1] = b_error;
				my[1] = a_value;
			end else if (be_z) begin
				ctrl_d.kind = uva_pkg::ERR_ONE;
			end else begin
				ctrl_d.kind   = uva_pkg::ERR_WORST;
				mx[1]         = sap;
				my[1]         = sbp;
				ctrl_d.ov_end = oap | oam | obp | obm;
			end
		end else if (command == uva_pkg::CMD_DIV) begin
			if (be_z)
				ctrl_d.kind = uva_pkg::ERR_ONE;
			else begin
				ctrl_d.kind = uva_pkg::ERR_WORST;
				if (ae_z) begin
					dx[1] = a_value;  dy[1] = sbp;
					dx[2] = a_value;  dy[2] = sbm;
					ctrl_d.ov_end = obp | obm;
				end else begin
					dx[1] = sap;      dy[1] = sbm;
					ctrl_d.ov_end = oap | oam | obp | obm;
				end
				ctrl_d.dz_err = (dy[1] == '0) || (dy[2] == '0);
			end
		end
		ctrl_d.dz_val = (command == uva_pkg::CMD_DIV) && (b_value == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctrl_s1 <= '0;
		else
			ctrl_s1 <= ctrl_d;
	end

	always_ff @(posedge clk) begin
		mx_s1 <= mx;
		my_s1 <= my;
		dx_s1 <= dx;
		dy_s1 <= dy;
	end

endmodule

FILE: rtl/core/uva_mul.sv
// ----------------------------------------------------------------------------
// uva_mul
// Two-stage fixed point multiplier with round half up.
// ----------------------------------------------------------------------------
module uva_mul #(
	parameter int FRAC_BITS = uva_pkg::FRAC_BITS,
	parameter int QW        = 2 * uva_pkg::DATA_W - FRAC_BITS
) (
	input  logic                               clk,
	input  logic signed [uva_pkg::DATA_W-1:0]  x,
	input  logic signed [uva_pkg::DATA_W-1:0]  y,
	output logic signed [QW-1:0]               q
);

	localparam int PW = 2 * uva_pkg::DATA_W;

	logic signed [PW-1:0] prod_s2;
	logic signed [PW-1:0] rnd;

	always_ff @(posedge clk) begin
		prod_s2 <= PW'(x) * PW'(y);
	end

	// upper bits of two's complement give the floor
	assign rnd = prod_s2 + (PW'(1) <<< (FRAC_BITS - 1));

	always_ff @(posedge clk) begin
		q <= rnd[PW-1:FRAC_BITS];
	end

endmodule

FILE: rtl/core/uva_div.sv
// ----------------------------------------------------------------------------
// uva_div
// Pipelined restoring divider, one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
module uva_div #(
	parameter int FRAC_BITS = uva_pkg::FRAC_BITS,
	parameter int NB        = uva_pkg::DATA_W + FRAC_BITS
) (
	input  logic                               clk,
	input  logic signed [uva_pkg::DATA_W-1:0]  x,
	input  logic signed [uva_pkg::DATA_W-1:0]  y,
	output logic signed [NB:0]                 q
);

	localparam int W = uva_pkg::DATA_W;

	logic [NB-1:0] num_s [0:NB];
	logic [NB-1:0] quo_s [0:NB];
	logic [W-1:0]  rem_s [0:NB];
	logic [W-1:0]  den_s [0:NB];
	logic          neg_s [0:NB];

	always_ff @(posedge clk) begin
		num_s[0] <= NB'(x[W-1] ? W'(-x) : W'(x)) << FRAC_BITS;
		den_s[0] <= y[W-1] ? W'(-y) : W'(y);
		neg_s[0] <= x[W-1] ^ y[W-1];
		rem_s[0] <= '0;
		quo_s[0] <= '0;
	end

	for (genvar g = 0; g < NB; g++) begin : g_step
		logic [W:0] trial;
		logic       ge;

		assign trial = {rem_s[g], num_s[g][NB-1]} - {1'b0, den_s[g]};
		assign ge    = !trial[W];

		always_ff @(posedge clk) begin
			rem_s[g+1] <= ge ? trial[W-1:0] : {rem_s[g][W-2:0], num_s[g][NB-1]};
			num_s[g+1] <= num_s[g] << 1;
			quo_s[g+1] <= {quo_s[g][NB-2:0], ge};
			den_s[g+1] <= den_s[g];
			neg_s[g+1] <= neg_s[g];
		end
	end

	always_ff @(posedge clk) begin
		q <= neg_s[NB] ? -$signed({1'b0, quo_s[NB]}) : $signed({1'b0, quo_s[NB]});
	end

endmodule

FILE: rtl/core/uva_back.sv
// ----------------------------------------------------------------------------
// uva_back
// Error combine: differences, magnitudes, worst case, saturation and status.
// ----------------------------------------------------------------------------
module uva_back #(
	parameter int RW = 2 * uva_pkg::DATA_W - 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  uva_pkg::ctrl_t                     ctrl,
	input  logic signed [RW-1:0]               mv [0:2],
	input  logic signed [RW-1:0]               dv [0:2],
	output logic                               done,
	output logic signed [uva_pkg::DATA_W-1:0]  res_value,
	output logic signed [uva_pkg::DATA_W-1:0]  res_error,
	output logic [1:0]                         status
);

	localparam int W  = uva_pkg::DATA_W;
	localparam int EW = RW + 2;

	uva_pkg::ctrl_t        ctrl_s1, ctrl_s2;
	logic signed [RW-1:0]  v_s1, v_s2, c1_s1, c1_s2;
	logic signed [RW:0]    d1_s1, d2_s1;
	logic [RW:0]           m1_s2, m2_s2;

	logic signed [EW-1:0]  ve, ee;
	logic                  ov;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			done    <= 1'b0;
		end else begin
			ctrl_s1 <= ctrl;
			ctrl_s2 <= ctrl_s1;
			done    <= ctrl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.cmd == uva_pkg::CMD_MUL) begin
			v_s1  <= mv[0];
			c1_s1 <= mv[1];
			d1_s1 <= (RW+1)'(mv[1]) - (RW+1)'(mv[0]);
			d2_s1 <= (RW+1)'(mv[2]) - (RW+1)'(mv[0]);
		end else begin
			v_s1  <= dv[0];
			c1_s1 <= dv[1];
			d1_s1 <= (RW+1)'(dv[1]) - (RW+1)'(dv[0]);
			d2_s1 <= (RW+1)'(dv[2]) - (RW+1)'(dv[0]);
		end
		v_s2  <= v_s1;
		c1_s2 <= c1_s1;
		m1_s2 <= d1_s1[RW] ? (RW+1)'(-d1_s1) : d1_s1;
		m2_s2 <= d2_s1[RW] ? (RW+1)'(-d2_s1) : d2_s1;
	end

	always_comb begin
		if (ctrl_s2.cmd == uva_pkg::CMD_ADD || ctrl_s2.cmd == uva_pkg::CMD_SUB) begin
			ve = EW'(ctrl_s2.sum_v);
			ee = EW'(ctrl_s2.sum_e);
		end else begin
			ve = EW'(v_s2);
			case (ctrl_s2.kind)
				uva_pkg::ERR_ONE:   ee = EW'(c1_s2);
				uva_pkg::ERR_WORST: ee = $signed({1'b0, (m1_s2 > m2_s2) ? m1_s2 : m2_s2});
				default:            ee = '0;
			endcase
		end
		ov = ctrl_s2.ov_end || ve > EW'(uva_pkg::S_MAX) || ve < EW'(uva_pkg::S_MIN)
			|| ee > EW'(uva_pkg::S_MAX) || ee < EW'(uva_pkg::S_MIN);
	end

	always_ff @(posedge clk) begin
		if (ctrl_s2.dz_val) begin
			res_value <= ctrl_s2.a_neg ? uva_pkg::S_MIN : uva_pkg::S_MAX;
			res_error <= uva_pkg::S_MAX;
			status    <= uva_pkg::STAT_DZ;
		end else begin
			if (ve > EW'(uva_pkg::S_MAX))
				res_value <= uva_pkg::S_MAX;
			else if (ve < EW'(uva_pkg::S_MIN))
				res_value <= uva_pkg::S_MIN;
			else
				res_value <= ve[W-1:0];
			if (ctrl_s2.dz_err || ee > EW'(uva_pkg::S_MAX))
				res_error <= uva_pkg::S_MAX;
			else if (ee < EW'(uva_pkg::S_MIN))
				res_error <= uva_pkg::S_MIN;
			else
				res_error <= ee[W-1:0];
			status <= ctrl_s2.dz_err ? uva_pkg::STAT_DZ :
				(ov ? uva_pkg::STAT_OVF : uva_pkg::STAT_OK);
		end
	end

endmodule

FILE: rtl/core/uncertain_value_alu_core.sv
// ----------------------------------------------------------------------------
// uncertain_value_alu_core
// Pipelined ALU on value/error pairs with worst case error propagation.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: drive command, a_value, a_error, b_value, b_error with start
//   high; the beat is taken on that edge since busy is always low. A new
//   beat may follow every cycle.
//   Result beat: done pulses for one cycle with res_value, res_error and
//   status. The receiver cannot stall, and none is needed: the pipeline
//   never holds.
//   Path: every command passes the decode register, the control delay
//   line and the combine registers. The delay is set by the divider,
//   which resolves one quotient bit per stage over 32 + FRAC_BITS
//   stages. Throughput is one beat per cycle.
//   Multiplies run in two stages and are delayed to line up with the
//   divider; results leave in input order.
//   Reset clears all valid bits; no done pulse follows until new beats enter.
// ----------------------------------------------------------------------------
module uncertain_value_alu_core #(
	parameter int FRAC_BITS = uva_pkg::FRAC_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         command,
	input  logic signed [uva_pkg::DATA_W-1:0]  a_value,
	input  logic signed [uva_pkg::DATA_W-1:0]  a_error,
	input  logic signed [uva_pkg::DATA_W-1:0]  b_value,
	input  logic signed [uva_pkg::DATA_W-1:0]  b_error,
	output logic                               done,
	output logic signed [uva_pkg::DATA_W-1:0]  res_value,
	output logic signed [uva_pkg::DATA_W-1:0]  res_error,
	output logic [1:0]                         status
);

	localparam int W   = uva_pkg::DATA_W;
	localparam int NB  = W + FRAC_BITS;
	localparam int QW  = 2 * W - FRAC_BITS;
	localparam int DW  = NB + 1;
	localparam int RW  = (QW > DW) ? QW : DW;
	localparam int CL  = NB + 2;
	localparam int MDL = NB;

	uva_pkg::ctrl_t      ctrl_s1;
	uva_pkg::ctrl_t      ctrl_dl [0:CL-1];
	logic signed [W-1:0] mx_s1 [0:2];
	logic signed [W-1:0] my_s1 [0:2];
	logic signed [W-1:0] dx_s1 [0:2];
	logic signed [W-1:0] dy_s1 [0:2];
	logic signed [QW-1:0] mq [0:2];
	logic signed [DW-1:0] dq [0:2];
	logic signed [QW-1:0] mq_dl [0:2][0:MDL-1];
	logic signed [RW-1:0] mv [0:2];
	logic signed [RW-1:0] dv [0:2];

	assign busy = 1'b0;

	uva_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.command  (command),
		.a_value  (a_value),
		.a_error  (a_error),
		.b_value  (b_value),
		.b_error  (b_error),
		.ctrl_s1  (ctrl_s1),
		.mx_s1    (mx_s1),
		.my_s1    (my_s1),
		.dx_s1    (dx_s1),
		.dy_s1    (dy_s1)
	);

	for (genvar u = 0; u < 3; u++) begin : g_unit
		uva_mul #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_mul (
			.clk (clk),
			.x   (mx_s1[u]),
			.y   (my_s1[u]),
			.q   (mq[u])
		);

		uva_div #(.FRAC_BITS(FRAC_BITS), .NB(NB)) u_div (
			.clk (clk),
			.x   (dx_s1[u]),
			.y   (dy_s1[u]),
			.q   (dq[u])
		);

		// align products with the divider output
		always_ff @(posedge clk) begin
			mq_dl[u][0] <= mq[u];
			for (int k = 1; k < MDL; k++)
				mq_dl[u][k] <= mq_dl[u][k-1];
		end

		assign mv[u] = RW'(mq_dl[u][MDL-1]);
		assign dv[u] = RW'(dq[u]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CL; k++)
				ctrl_dl[k] <= '0;
		end else begin
			ctrl_dl[0] <= ctrl_s1;
			for (int k = 1; k < CL; k++)
				ctrl_dl[k] <= ctrl_dl[k-1];
		end
	end

	uva_back #(.RW(RW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl_dl[CL-1]),
		.mv        (mv),
		.dv        (dv),
		.done      (done),
		.res_value (res_value),
		.res_error (res_error),
		.status    (status)
	);

`ifndef SYNTHESIS
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == uva_pkg::STAT_OK || status == uva_pkg::STAT_DZ
			|| status == uva_pkg::STAT_OVF))
		else $error("undefined status code");

	a_dz_error: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == uva_pkg::STAT_DZ) |-> (res_error == uva_pkg::S_MAX))
		else $error("divide by zero without saturated error");

	// three register stages in the combine unit
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(ctrl_dl[CL-1].valid, 3))
		else $error("result strobe without a beat in flight");
`endif

endmodule
